FILE: hw/rtl/pwc_pkg.sv
// ----------------------------------------------------------------------------
// Pulse width capture package
// Request and response payloads, field codes, internal control structs and
// the width arithmetic shared by the capture unit.
// ----------------------------------------------------------------------------
package pwc_pkg;

   // Fixed field widths of the request and response payloads.
   localparam int CH_BITS     = 3;
   localparam int MAX_CH      = 8;
   localparam int TS_BITS     = 16;
   localparam int WIDTH_BITS  = 16;
   localparam int PERIOD_BITS = 16;

   // Request kind codes.
   localparam logic KIND_EDGE = 1'b0;
   localparam logic KIND_POLL = 1'b1;

   // Pin level after an edge.
   localparam logic LEVEL_FALL = 1'b0;
   localparam logic LEVEL_RISE = 1'b1;

   // Timer period after reset.
   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 16'hFFFF;

   typedef struct packed {
      logic                kind;
      logic [CH_BITS-1:0]  channel;
      logic                level;
      logic [TS_BITS-1:0]  timestamp;
   } req_type;

   typedef struct packed {
      logic [CH_BITS-1:0]    out_channel;
      logic [WIDTH_BITS-1:0] pulse_width;
      logic                  fresh;
      logic                  last;
   } rsp_type;

   // Edge write into the time store.
   typedef struct packed {
      logic               en;
      logic               rise;
      logic [CH_BITS-1:0] chan;
      logic [TS_BITS-1:0] stamp;
   } edge_wr_type;

   // Per-channel flags that come back with a time store read.
   typedef struct packed {
      logic pending;
      logic rise_valid;
   } ts_flags_type;

   // Width of a pulse, with the rollover correction when the end time is
   // not past the start time. The result is kept modulo 2^16.
   function automatic logic [WIDTH_BITS-1:0] compute_width(
      input logic [PERIOD_BITS-1:0] period,
      input logic [WIDTH_BITS-1:0]  start,
      input logic [WIDTH_BITS-1:0]  stop
   );
      logic [WIDTH_BITS:0] sum;
      sum = {1'b0, period} + {1'b0, stop} - {1'b0, start};
      if (stop > start) begin
         return stop - start;
      end
      return sum[WIDTH_BITS-1:0];
   endfunction

endpackage

FILE: hw/rtl/pwc_req_if.sv
// ----------------------------------------------------------------------------
// Pulse width capture request channel
// Valid/ready channel that carries edge events and poll requests.
// ----------------------------------------------------------------------------
interface pwc_req_if;
   import pwc_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/pwc_rsp_if.sv
// ----------------------------------------------------------------------------
// Pulse width capture response channel
// Valid/ready channel that carries one channel width per response.
// ----------------------------------------------------------------------------
interface pwc_rsp_if;
   import pwc_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/pwc_time_store.sv
// ----------------------------------------------------------------------------
// Pulse width capture time store
// Start and end time memory per channel with pending and start-valid flags.
// Reads are registered.
// ----------------------------------------------------------------------------
module pwc_time_store #(
   parameter int ACTIVE = 8,
   parameter int CH_W   = 3,
   parameter int TW     = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  pwc_pkg::edge_wr_type       edge_wr,
   input  logic                       rd_en,
   input  logic [CH_W-1:0]            rd_addr,
   input  logic                       clr_en,
   input  logic [CH_W-1:0]            clr_addr,
   output logic [TW-1:0]              rd_rise,
   output logic [TW-1:0]              rd_fall,
   output pwc_pkg::ts_flags_type      rd_flags
);
   import pwc_pkg::*;

   logic [TW-1:0]     rise_mem [ACTIVE];
   logic [TW-1:0]     fall_mem [ACTIVE];
   logic [TW-1:0]     rd_rise_ff;
   logic [TW-1:0]     rd_fall_ff;
   ts_flags_type      rd_flags_ff;
   ts_flags_type      rd_flags_in;
   logic [ACTIVE-1:0] pending_ff;
   logic [ACTIVE-1:0] pending_in;
   logic [ACTIVE-1:0] rise_valid_ff;
   logic [ACTIVE-1:0] rise_valid_in;
   logic [CH_W-1:0]   wr_addr;
   logic              wr_rise;
   logic              wr_fall;

   assign wr_addr = edge_wr.chan[CH_W-1:0];
   assign wr_rise = edge_wr.en && (edge_wr.rise == LEVEL_RISE);
   assign wr_fall = edge_wr.en && (edge_wr.rise == LEVEL_FALL);

   // Time memory: written by edge events, read by the poll sequencer.
   always_ff @(posedge clock) begin
      if (wr_rise) begin
         rise_mem[wr_addr] <= edge_wr.stamp[TW-1:0];
      end
      if (wr_fall) begin
         fall_mem[wr_addr] <= edge_wr.stamp[TW-1:0];
      end
      if (rd_en) begin
         rd_rise_ff <= rise_mem[rd_addr];
         rd_fall_ff <= fall_mem[rd_addr];
      end
   end

   // Pending and start-valid flags, and the flags that travel with a read.
   always_comb begin
      pending_in    = pending_ff;
      rise_valid_in = rise_valid_ff;
      rd_flags_in   = rd_flags_ff;
      if (clr_en) begin
         pending_in[clr_addr] = 1'b0;
      end
      if (wr_fall) begin
         pending_in[wr_addr] = 1'b1;
      end
      if (wr_rise) begin
         rise_valid_in[wr_addr] = 1'b1;
      end
      if (rd_en) begin
         rd_flags_in.pending    = pending_ff[rd_addr];
         rd_flags_in.rise_valid = rise_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         rise_valid_ff <= '0;
         rd_flags_ff   <= '0;
      end else begin
         pending_ff    <= pending_in;
         rise_valid_ff <= rise_valid_in;
         rd_flags_ff   <= rd_flags_in;
      end
   end

   // A start time that was never written reads as zero.
   assign rd_rise  = rd_flags_ff.rise_valid ? rd_rise_ff : '0;
   assign rd_fall  = rd_fall_ff;
   assign rd_flags = rd_flags_ff;

endmodule

FILE: hw/rtl/pwc_width_store.sv
// ----------------------------------------------------------------------------
// Pulse width capture width store
// Latest measured width per channel. Reads are registered; an
// entry never written reads as zero.
// ----------------------------------------------------------------------------
module pwc_width_store #(
   parameter int ACTIVE = 8,
   parameter int CH_W   = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rd_en,
   input  logic [CH_W-1:0]                   rd_addr,
   input  logic                              wr_en,
   input  logic [CH_W-1:0]                   wr_addr,
   input  logic [pwc_pkg::WIDTH_BITS-1:0]    wr_data,
   output logic [pwc_pkg::WIDTH_BITS-1:0]    rd_data
);
   import pwc_pkg::*;

   logic [WIDTH_BITS-1:0] width_mem [ACTIVE];
   logic [WIDTH_BITS-1:0] rd_data_ff;
   logic [ACTIVE-1:0]     valid_ff;
   logic [ACTIVE-1:0]     valid_in;
   logic                  rd_valid_ff;
   logic                  rd_valid_in;

   // Width memory.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         width_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= width_mem[rd_addr];
      end
   end

   // Written flags per entry, sampled with each read.
   always_comb begin
      valid_in    = valid_ff;
      rd_valid_in = rd_valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      if (rd_en) begin
         rd_valid_in = valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

FILE: hw/rtl/multi_channel_pulse_width_capture_unit.sv
// Measures pulse high times on up to eight capture channels. An edge event
// returns no response: a rising edge stores the start time, a falling edge
// stores the end time and marks the channel pending. A poll returns one
// response per active channel, channel 0 first, at one response per cycle
// while the response side is ready; the poll passes through the sequencer,
// the memory read stage and the response register, and the next request is
// taken once the last channel has left the memory read stage. The single
// read port of the time and width memories is walked by the poll sequencer
// one channel per cycle while the response side is ready. Pending widths
// are computed during the walk and written back; a pulse whose end time is
// not past its start time is corrected with the timer period written
// through csr_.
// ----------------------------------------------------------------------------
// Multi-channel pulse width capture unit
// Top level: request decode, poll sequencer, width computation, response
// register and the timer period register.
// ----------------------------------------------------------------------------
module multi_channel_pulse_width_capture_unit #(
   parameter int CHANNELS  = 8,
   parameter int TIME_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   pwc_req_if.sink                           req_chan,
   pwc_rsp_if.source                         rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [pwc_pkg::PERIOD_BITS-1:0]   csr_wr_data
);
   import pwc_pkg::*;

   localparam int ACTIVE = (CHANNELS < MAX_CH) ? CHANNELS : MAX_CH;
   localparam int CH_W   = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
   localparam int TW     = (TIME_BITS < TS_BITS) ? TIME_BITS : TS_BITS;
   localparam logic [CH_W-1:0]    LAST_IDX   = CH_W'(ACTIVE - 1);
   localparam logic [CH_BITS:0]   ACTIVE_CNT = (CH_BITS + 1)'(ACTIVE);

   logic [PERIOD_BITS-1:0] period_ff;
   logic [PERIOD_BITS-1:0] period_in;
   logic                   seq_active_ff;
   logic                   seq_active_in;
   logic [CH_W-1:0]        seq_idx_ff;
   logic [CH_W-1:0]        seq_idx_in;
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic [CH_W-1:0]        s1_idx_ff;
   logic [CH_W-1:0]        s1_idx_in;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   rsp_type                out_payload_ff;
   rsp_type                out_payload_in;

   logic                   busy;
   logic                   req_fire;
   logic                   poll_start;
   logic                   out_free;
   logic                   s1_move;
   logic                   rd_en;
   logic                   wb_en;
   edge_wr_type            edge_wr;
   logic [TW-1:0]          rd_rise;
   logic [TW-1:0]          rd_fall;
   ts_flags_type           rd_flags;
   logic [WIDTH_BITS-1:0]  old_width;
   logic [WIDTH_BITS-1:0]  new_width;

   // Request decode. A poll holds off further requests until its walk has
   // left the read stage.
   assign busy           = seq_active_ff || s1_valid_ff;
   assign req_chan.ready = !busy;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign poll_start     = req_fire && (req_chan.payload.kind == KIND_POLL);

   always_comb begin
      edge_wr       = '0;
      edge_wr.en    = req_fire && (req_chan.payload.kind == KIND_EDGE) &&
                      ({1'b0, req_chan.payload.channel} < ACTIVE_CNT);
      edge_wr.rise  = req_chan.payload.level;
      edge_wr.chan  = req_chan.payload.channel;
      edge_wr.stamp = req_chan.payload.timestamp;
   end

   // Pipeline advance: the read stage moves into the response register when
   // that register is empty or being drained.
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign s1_move  = s1_valid_ff && out_free;
   assign rd_en    = seq_active_ff && (!s1_valid_ff || s1_move);
   assign wb_en    = s1_move && rd_flags.pending;

   // Poll sequencer and read stage tracking.
   always_comb begin
      seq_active_in = seq_active_ff;
      seq_idx_in    = seq_idx_ff;
      s1_valid_in   = s1_valid_ff;
      s1_idx_in     = s1_idx_ff;
      if (poll_start) begin
         seq_active_in = 1'b1;
         seq_idx_in    = '0;
      end else if (rd_en) begin
         if (seq_idx_ff == LAST_IDX) begin
            seq_active_in = 1'b0;
         end else begin
            seq_idx_in = seq_idx_ff + 1'b1;
         end
      end
      if (rd_en) begin
         s1_valid_in = 1'b1;
         s1_idx_in   = seq_idx_ff;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   pwc_time_store #(
      .ACTIVE (ACTIVE),
      .CH_W   (CH_W),
      .TW     (TW)
   ) u_time_store (
      .clock    (clock),
      .reset    (reset),
      .edge_wr  (edge_wr),
      .rd_en    (rd_en),
      .rd_addr  (seq_idx_ff),
      .clr_en   (wb_en),
      .clr_addr (s1_idx_ff),
      .rd_rise  (rd_rise),
      .rd_fall  (rd_fall),
      .rd_flags (rd_flags)
   );

   pwc_width_store #(
      .ACTIVE (ACTIVE),
      .CH_W   (CH_W)
   ) u_width_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (seq_idx_ff),
      .wr_en   (wb_en),
      .wr_addr (s1_idx_ff),
      .wr_data (new_width),
      .rd_data (old_width)
   );

   // Width of a pending channel, otherwise the stored width.
   assign new_width = rd_flags.pending ?
                      compute_width(period_ff, WIDTH_BITS'(rd_rise), WIDTH_BITS'(rd_fall)) :
                      old_width;

   // Response register.
   always_comb begin
      out_valid_in   = out_valid_ff;
      out_payload_in = out_payload_ff;
      if (s1_move) begin
         out_valid_in               = 1'b1;
         out_payload_in.out_channel = CH_BITS'(s1_idx_ff);
         out_payload_in.pulse_width = new_width;
         out_payload_in.fresh       = rd_flags.pending;
         out_payload_in.last        = (s1_idx_ff == LAST_IDX);
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_payload_ff;

   // Timer period register.
   assign period_in = csr_wr_en ? csr_wr_data : period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= PERIOD_RESET;
         seq_active_ff <= 1'b0;
         seq_idx_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         s1_idx_ff     <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         period_ff     <= period_in;
         seq_active_ff <= seq_active_in;
         seq_idx_ff    <= seq_idx_in;
         s1_valid_ff   <= s1_valid_in;
         s1_idx_ff     <= s1_idx_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_payload_ff <= out_payload_in;
   end

endmodule
